/* rtl/core/fas_pkg.sv */
`default_nettype none

package fas_pkg;

  // Fixed field widths of the steering interface.
  localparam int CPU_W  = 4;
  localparam int CFG_W  = 5;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;

  // Processor that every new flow falls back to, and the pointer's reset value.
  localparam logic [CPU_W-1:0] FIRST_CPU = CPU_W'(1);

  // Reset value of the processor count register.
  localparam logic [CFG_W-1:0] CPU_COUNT_RST = CFG_W'(2);

  // Hardware ceiling on the processor count, set by the target field width.
  localparam int CPU_CEIL = 1 << CPU_W;

  // Flow key as held in the table.
  typedef struct packed {
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [PORT_W-1:0] dst_port;
    logic [PORT_W-1:0] src_port;
  } fas_key_t;

  // Lookup answer from the flow table.
  typedef struct packed {
    logic             hit;
    logic [CPU_W-1:0] target;
    logic             full;
  } fas_lookup_t;

  // Insert request into the flow table.
  typedef struct packed {
    logic             we;
    logic [CPU_W-1:0] target;
  } fas_insert_t;

endpackage

`default_nettype wire

/* rtl/core/flow_affinity_steering.sv */
// Flow affinity steering: picks the processor for each TCP packet header.
// Input channel (in_*): one request per header, holding destination and
// source address and port. Output channel (out_*): one result per request,
// in order, giving target_cpu, new_flow and table_full.
// Config channel (cfg_*): writes the processor count; write only while idle.
// A known flow returns its stored processor. A new flow takes the
// round-robin pointer, which cycles over processors 1 to count-1, and is
// stored while the table has room; otherwise table_full is raised.
// Pipeline: the input register loads at the accepting edge, and the result
// register loads from it once free, which raises out_valid.
// Throughput: one request per cycle while out_ready stays high, set by the
// combinational parallel compare across the flow table.
// Stall: while out_valid is high and out_ready low, the result holds and the
// input register holds its request; in_ready drops once both are full.
// Reset: the flow table empties, the pointer returns to processor 1 and the
// processor count returns to 2.
`default_nettype none

module flow_affinity_steering #(
  parameter int FLOWS    = 64,
  parameter int MAX_CPUS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fas_pkg::ADDR_W-1:0]    in_dst_addr,
  input  wire logic [fas_pkg::PORT_W-1:0]    in_dst_port,
  input  wire logic [fas_pkg::ADDR_W-1:0]    in_src_addr,
  input  wire logic [fas_pkg::PORT_W-1:0]    in_src_port,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fas_pkg::CPU_W-1:0]          out_target_cpu,
  output logic                               out_new_flow,
  output logic                               out_table_full,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fas_pkg::CFG_W-1:0]     cfg_cpu_count
);
  import fas_pkg::*;

  localparam int LIMIT = (MAX_CPUS < CPU_CEIL) ? MAX_CPUS : CPU_CEIL;

  logic             in_valid_r;
  fas_key_t         key_r;
  logic             out_valid_r;
  logic [CPU_W-1:0] out_target_cpu_r;
  logic             out_new_flow_r;
  logic             out_table_full_r;
  logic [CFG_W-1:0] cpu_count_r;
  logic [CPU_W-1:0] rr_pointer_r;
  logic [CPU_W-1:0] rr_pointer_nxt;
  logic [CFG_W-1:0] count_eff;
  logic [CPU_W-1:0] rr_cur;
  logic [CFG_W-1:0] rr_next;
  logic             advance;
  fas_lookup_t      lookup;
  fas_insert_t      ins;

  // Handshake: the request moves to the result register when it is free.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_target_cpu = out_target_cpu_r;
  assign out_new_flow   = out_new_flow_r;
  assign out_table_full = out_table_full_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r.dst_addr <= in_dst_addr;
      key_r.src_addr <= in_src_addr;
      key_r.dst_port <= in_dst_port;
      key_r.src_port <= in_src_port;
    end
  end

  // Processor count register; the effective count is clamped to MAX_CPUS and to what the target field can name.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_count_r <= CPU_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      cpu_count_r <= cfg_cpu_count;
    end
  end

  assign count_eff = (cpu_count_r > CFG_W'(LIMIT)) ? CFG_W'(LIMIT) : cpu_count_r;

  // Round-robin choice; a pointer left beyond a lowered count restarts at one.
  always_comb begin
    rr_cur  = ({1'b0, rr_pointer_r} < count_eff) ? rr_pointer_r : FIRST_CPU;
    rr_next = {1'b0, rr_cur} + CFG_W'(1);
    if (rr_next >= count_eff) begin
      rr_next = {1'b0, FIRST_CPU};
    end
    rr_pointer_nxt = rr_pointer_r;
    if (advance && !lookup.hit) begin
      rr_pointer_nxt = rr_next[CPU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_pointer_r <= FIRST_CPU;
    end else begin
      rr_pointer_r <= rr_pointer_nxt;
    end
  end

  // Flow table: lookup and insert happen in the same cycle as the result load.
  assign ins.we     = advance && !lookup.hit;
  assign ins.target = rr_cur;

  fas_flow_table #(
    .FLOWS (FLOWS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .key    (key_r),
    .ins    (ins),
    .lookup (lookup)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_target_cpu_r <= lookup.hit ? lookup.target : rr_cur;
      out_new_flow_r   <= !lookup.hit;
      out_table_full_r <= !lookup.hit && lookup.full;
    end
  end

  // Processor zero is never handed out.
  a_no_cpu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_target_cpu_r != '0))
    else $error("result steered to processor zero");

  // A full-table report only comes with a new flow.
  a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_table_full_r) |-> out_new_flow_r)
    else $error("table full raised on a hit");

  // The pointer never rests on processor zero.
  a_ptr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rr_pointer_r != '0)
    else $error("round-robin pointer reached processor zero");

  // The pointer moves only when a new flow leaves the input register.
  a_ptr_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (rr_pointer_r != $past(rr_pointer_r)) |-> ($past(advance) && !$past(lookup.hit)))
    else $error("round-robin pointer moved without a new flow");

endmodule

`default_nettype wire

/* rtl/core/fas_flow_table.sv */
`default_nettype none

module fas_flow_table #(
  parameter int FLOWS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fas_pkg::fas_key_t   key,
  input  wire fas_pkg::fas_insert_t ins,
  output fas_pkg::fas_lookup_t     lookup
);
  import fas_pkg::*;

  localparam int CNT_W = $clog2(FLOWS + 1);
  localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  // Entry storage; entries fill in order and are never removed.
  fas_key_t         key_r [FLOWS];
  logic [CPU_W-1:0] tgt_r [FLOWS];
  logic [CNT_W-1:0] fill_count_r;
  logic [CNT_W-1:0] fill_count_nxt;
  logic [FLOWS-1:0] match;
  logic             full;

  assign full = (fill_count_r == CNT_W'(FLOWS));

  // Parallel compare against every filled entry. An entry is in use when its
  // index is below the fill count, so no per-entry valid bit is kept.
  always_comb begin
    logic [CPU_W-1:0] tgt;
    tgt = '0;
    for (int i = 0; i < FLOWS; i++) begin
      match[i] = (CNT_W'(i) < fill_count_r) && (key_r[i] == key);
      tgt      = tgt | ({CPU_W{match[i]}} & tgt_r[i]);
    end
    lookup.hit    = |match;
    lookup.target = tgt;
    lookup.full   = full;
  end

  // A new flow is stored at the fill position while there is room.
  always_comb begin
    fill_count_nxt = fill_count_r;
    if (ins.we && !full) begin
      fill_count_nxt = fill_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else begin
      fill_count_r <= fill_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins.we && !full) begin
      key_r[fill_count_r[IDX_W-1:0]] <= key;
      tgt_r[fill_count_r[IDX_W-1:0]] <= ins.target;
    end
  end

  // A flow is stored only on a miss, so no key can sit in two entries.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("flow key matched more than one table entry");

  // The fill count never runs past the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(FLOWS))
    else $error("fill count exceeds table depth");

  // The fill count moves only on an insert into a table with room.
  a_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r != $past(fill_count_r)) |-> ($past(ins.we) && !$past(full)))
    else $error("fill count changed without an insert");

  // Inserts come only on a miss.
  a_insert_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ins.we |-> !lookup.hit)
    else $error("insert requested for a flow already in the table");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fas_pkg::*;

  localparam int FLOWS          = 64;
  localparam int MAX_CPUS       = 16;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_REQUESTS = 72;
  localparam int MAX_WAIT       = 8;
  localparam int SETTLE_CYCLES  = 4;
  localparam int IDLE_LIMIT     = 500;

  // One steering decision as it leaves the block.
  typedef struct packed {
    logic [CPU_W-1:0] target_cpu;
    logic             new_flow;
    logic             table_full;
  } steer_result_t;

  // One line of the directed table: an optional count write, then a request.
  typedef struct packed {
    logic             cfg_write;
    logic [CFG_W-1:0] cfg_value;
    fas_key_t         hdr;
    logic             typed;
    steer_result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] in_dst_addr = '0;
  logic [PORT_W-1:0] in_dst_port = '0;
  logic [ADDR_W-1:0] in_src_addr = '0;
  logic [PORT_W-1:0] in_src_port = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CPU_W-1:0] out_target_cpu;
  logic out_new_flow;
  logic out_table_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_cpu_count = '0;

  // Shadow of the flow table, the round-robin pointer and the count register.
  fas_key_t         flow_key [FLOWS];
  logic [CPU_W-1:0] flow_cpu [FLOWS];
  int               stored_flows = 0;
  int               rr_cpu = FIRST_CPU;
  logic [CFG_W-1:0] cpu_limit = CPU_COUNT_RST;

  steer_result_t pending_steers[$];
  fas_key_t      sent_headers[$];
  bit            no_idle = 1'b0;
  int            fail_count = 0;
  int            hit_count = 0;
  int            fresh_count = 0;
  int            refused_count = 0;
  int            count_writes = 0;
  int            quiet_cycles = 0;

  flow_affinity_steering #(
    .FLOWS   (FLOWS),
    .MAX_CPUS(MAX_CPUS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dst_addr   (in_dst_addr),
    .in_dst_port   (in_dst_port),
    .in_src_addr   (in_src_addr),
    .in_src_port   (in_src_port),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_target_cpu(out_target_cpu),
    .out_new_flow  (out_new_flow),
    .out_table_full(out_table_full),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_cpu_count (cfg_cpu_count)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fas_key_t make_header(input logic [ADDR_W-1:0] dst_addr,
                                           input logic [PORT_W-1:0] dst_port,
                                           input logic [ADDR_W-1:0] src_addr,
                                           input logic [PORT_W-1:0] src_port);
    fas_key_t hdr;
    hdr.dst_addr = dst_addr;
    hdr.dst_port = dst_port;
    hdr.src_addr = src_addr;
    hdr.src_port = src_port;
    return hdr;
  endfunction

  // Looks the header up in the shadow table; a miss takes the pointer and is
  // stored while there is room.
  function automatic steer_result_t predict_steering(input fas_key_t hdr);
    steer_result_t res;
    int i;
    int n;
    int cur;
    int nxt;
    res = '0;
    for (i = 0; i < stored_flows; i++) begin
      if (flow_key[i] == hdr) begin
        res.target_cpu = flow_cpu[i];
        hit_count++;
        return res;
      end
    end
    n = cpu_limit;
    if (n > MAX_CPUS) n = MAX_CPUS;
    if (n > CPU_CEIL) n = CPU_CEIL;
    cur = (rr_cpu < n) ? rr_cpu : FIRST_CPU;
    nxt = cur + 1;
    if (nxt >= n) nxt = FIRST_CPU;
    rr_cpu = nxt;
    res.target_cpu = cur[CPU_W-1:0];
    res.new_flow = 1'b1;
    if (stored_flows < FLOWS) begin
      flow_key[stored_flows] = hdr;
      flow_cpu[stored_flows] = cur[CPU_W-1:0];
      stored_flows++;
      fresh_count++;
    end else begin
      res.table_full = 1'b1;
      refused_count++;
    end
    return res;
  endfunction

  // Presents one request after a random gap and holds it until accepted.
  task automatic send_header(input fas_key_t hdr, input logic typed,
                             input steer_result_t want);
    int gap;
    steer_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_dst_addr <= hdr.dst_addr;
    in_dst_port <= hdr.dst_port;
    in_src_addr <= hdr.src_addr;
    in_src_port <= hdr.src_port;
    do @(posedge clk); while (!(in_valid && in_ready));
    predicted = predict_steering(hdr);
    pending_steers.push_back(typed ? want : predicted);
    sent_headers.push_back(hdr);
  endtask

  // Drops the request line and waits until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_steers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cpu_count(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid     <= 1'b1;
    cfg_cpu_count <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cpu_limit = value;
    count_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Builds a random header: mostly repeats and near-repeats of earlier flows,
  // with corner values and fresh flows mixed in.
  function automatic fas_key_t random_header();
    fas_key_t hdr;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45 && sent_headers.size() != 0) begin
      hdr = sent_headers[$urandom_range(0, sent_headers.size() - 1)];
    end else if (pick < 55 && sent_headers.size() != 0) begin
      hdr = sent_headers[$urandom_range(0, sent_headers.size() - 1)];
      hdr = fas_key_t'(hdr ^ ($bits(fas_key_t)'(1) << $urandom_range(0, $bits(fas_key_t) - 1)));
    end else if (pick < 62) begin
      hdr.dst_addr = ($urandom_range(0, 2) == 0) ? '0 :
                     ($urandom_range(0, 1) == 0) ? '1 : ADDR_W'($urandom);
      hdr.src_addr = ($urandom_range(0, 2) == 0) ? '0 :
                     ($urandom_range(0, 1) == 0) ? '1 : ADDR_W'($urandom);
      hdr.dst_port = ($urandom_range(0, 2) == 0) ? '0 :
                     ($urandom_range(0, 1) == 0) ? '1 : PORT_W'($urandom);
      hdr.src_port = ($urandom_range(0, 2) == 0) ? '0 :
                     ($urandom_range(0, 1) == 0) ? '1 : PORT_W'($urandom);
    end else begin
      hdr = make_header(ADDR_W'($urandom), PORT_W'($urandom),
                        ADDR_W'($urandom), PORT_W'($urandom));
    end
    return hdr;
  endfunction

  // Result side: a random stall before each result is taken.
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    steer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steers.size() == 0) begin
        $error("Result with no request outstanding: target_cpu %0d", out_target_cpu);
        fail_count++;
      end else begin
        want = pending_steers.pop_front();
        if (out_target_cpu !== want.target_cpu) begin
          $error("target_cpu: expected %0d, got %0d", want.target_cpu, out_target_cpu);
          fail_count++;
        end
        if (out_new_flow !== want.new_flow) begin
          $error("new_flow: expected %0b, got %0b", want.new_flow, out_new_flow);
          fail_count++;
        end
        if (out_table_full !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, out_table_full);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no handshake completes for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    stim_row_t directed_rows[$];
    int phase_counts[RANDOM_PHASES];
    int row;
    int phase;
    int k;

    phase_counts = '{16, 2, 31, 5, 0, 15, 1, 17, 0};
    phase_counts[RANDOM_PHASES-1] = $urandom_range(0, 31);

    // After reset the count is 2, so every new flow lands on processor 1.
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header('0, '0, '0, '0),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b1, 1'b0}});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header('1, '1, '1, '1),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b1, 1'b0}});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header('0, '0, '0, '0),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b0, 1'b0}});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header('1, '1, '1, '1),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b0, 1'b0}});
    // Keys differing in a single field are distinct flows.
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header('1, '0, '0, '0),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b1, 1'b0}});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header('0, '0, '0, '1),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b1, 1'b0}});
    // Full processor range: the pointer walks upward.
    directed_rows.push_back(stim_row_t'{1'b1, 5'd16,
                            make_header(32'hAAAAAAAA, 16'h5555, 32'h55555555, 16'hAAAA),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'h55555555, 16'hAAAA, 32'hAAAAAAAA, 16'h5555),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header(32'd1, 16'd2, 32'd3, 16'd4),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'h0A000001, 16'd80, 32'hC0A80001, 16'd1024),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'h0A000001, 16'd443, 32'hC0A80001, 16'd1024),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'h7F000001, 16'd8080, 32'h7F000001, 16'd65000),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'hAAAAAAAA, 16'h5555, 32'h55555555, 16'hAAAA),
                            1'b0, '0});
    // Count above the ceiling is clamped to 16.
    directed_rows.push_back(stim_row_t'{1'b1, 5'd31,
                            make_header(32'h80000000, 16'h8000, 32'h00000001, 16'h0001),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'h00000001, 16'h0001, 32'h80000000, 16'h8000),
                            1'b0, '0});
    // Lowering the count leaves the pointer beyond it.
    directed_rows.push_back(stim_row_t'{1'b1, 5'd3,
                            make_header(32'h12345678, 16'h9ABC, 32'hDEF01234, 16'h5678),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'h87654321, 16'h0FED, 32'hCBA98765, 16'h4321),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0,
                            make_header(32'hFFFF0000, 16'h00FF, 32'h0000FFFF, 16'hFF00),
                            1'b0, '0});
    // Counts below two give processor 1 only.
    directed_rows.push_back(stim_row_t'{1'b1, 5'd1,
                            make_header(32'h01010101, 16'h0101, 32'h02020202, 16'h0202),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b1, 1'b0}});
    directed_rows.push_back(stim_row_t'{1'b1, 5'd0,
                            make_header(32'h03030303, 16'h0303, 32'h04040404, 16'h0404),
                            1'b1, steer_result_t'{FIRST_CPU, 1'b1, 1'b0}});
    directed_rows.push_back(stim_row_t'{1'b0, 5'd0, make_header(32'd1, 16'd2, 32'd3, 16'd4),
                            1'b0, '0});
    directed_rows.push_back(stim_row_t'{1'b1, 5'd17,
                            make_header(32'h11111111, 16'h2222, 32'h33333333, 16'h4444),
                            1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < directed_rows.size(); row++) begin
      if (directed_rows[row].cfg_write) begin
        write_cpu_count(directed_rows[row].cfg_value);
      end
      send_header(directed_rows[row].hdr, directed_rows[row].typed, directed_rows[row].want);
    end

    // Random phases; the second one runs without any idling on either side.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_cpu_count(phase_counts[phase][CFG_W-1:0]);
      no_idle = (phase == 1) || ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        send_header(random_header(), 1'b0, '0);
      end
    end
    drain_results();

    $display("Steered %0d headers: %0d flow hits, %0d flows stored, %0d refused by the full table.",
             sent_headers.size(), hit_count, fresh_count, refused_count);
    $display("Processor count written %0d times, including 0, 1, 16, 17 and 31.", count_writes);
    if (fail_count == 0 && pending_steers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
